FILE: rtl/core/lfu_pkg.sv
// Shared constants and types for the LFU cache replacement core.
// No dependencies; imported by the scan unit and the top level.
package lfu_pkg;

  localparam int TAG_W     = 32;
  localparam int MISS_W    = 32;
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;  // start a fresh search
    logic step;   // one entry beat is on the read data
  } scan_ctl_t;

endpackage

FILE: rtl/core/lfu_entry_ram.sv
// Entry store: one write port and one read port with registered read data.
// No package dependencies.
module lfu_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 52
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/lfu_scan.sv
// Scan unit: looks at one entry per beat, tracking the tag match, the
// replacement victim (lowest count, then lowest rank) and the first free slot.
// Depends on lfu_pkg.
module lfu_scan #(
  parameter int IW         = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  lfu_pkg::scan_ctl_t         ctl,
  input  logic [lfu_pkg::TAG_W-1:0]  key,
  input  logic                       ent_valid,
  input  logic [IW-1:0]              ent_idx,
  input  logic [lfu_pkg::TAG_W-1:0]  ent_tag,
  input  logic [COUNT_BITS-1:0]      ent_count,
  input  logic [IW-1:0]              ent_rank,
  output logic                       hit_found,
  output logic [IW-1:0]              hit_idx,
  output logic [IW-1:0]              hit_rank,
  output logic                       vic_found,
  output logic [IW-1:0]              vic_idx,
  output logic [IW-1:0]              vic_rank,
  output logic [lfu_pkg::TAG_W-1:0]  vic_tag,
  output logic                       free_found,
  output logic [IW-1:0]              free_idx
);
  import lfu_pkg::*;

  logic [COUNT_BITS+IW-1:0] best;
  logic [COUNT_BITS+IW-1:0] cand;
  logic                     better;

  // Ranks of valid entries are distinct, so the joint key is a strict order.
  assign cand     = {ent_count, ent_rank};
  assign better   = !vic_found || (cand < best);
  assign vic_rank = best[IW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (ctl.step) begin
      if (ent_valid) begin
        if (!hit_found && ent_tag == key) begin
          hit_found <= 1'b1;
          hit_idx   <= ent_idx;
          hit_rank  <= ent_rank;
        end
        if (better) begin
          vic_found <= 1'b1;
          best      <= cand;
          vic_idx   <= ent_idx;
          vic_tag   <= ent_tag;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= ent_idx;
      end
    end
  end

endmodule

FILE: rtl/core/lfu_cache_replacement_core.sv
// Fully associative cache directory with least-frequently-used replacement.
// An accepted block_id passes the scan pass, the decide state, the update pass
// and the done state before its result beat is in the output register; the next
// block_id is taken once the core is back in idle after that, which comes later
// only while a finished result cannot move into a still full output register.
// One pass reads every entry from the entry store through the scan unit to
// find a hit, the victim and a free slot. A second read-modify-write pass over
// the same store ages the recency ranks and writes the touched entry. The store
// reads one entry per cycle, which sets both passes. in_ready is high only
// between items; a finished result waits in the output register while the next
// item is taken. capacity may be written at any idle time and takes effect on
// the next item. No clearing pass is needed after reset: per-entry valid bits
// start cleared.
// Depends on lfu_pkg, lfu_entry_ram and lfu_scan.
module lfu_cache_replacement_core #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lfu_pkg::TAG_W-1:0]   block_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic                        evicted,
  output logic [lfu_pkg::TAG_W-1:0]   evicted_id,
  output logic [lfu_pkg::MISS_W-1:0]  misses_so_far
);
  import lfu_pkg::*;

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = IW + 1;
  localparam int OW    = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OW > CAP_W) ? OW : CAP_W;
  localparam int DW    = TAG_W + COUNT_BITS + IW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]             state;
  logic [CAP_W-1:0]       capacity;
  logic [OW-1:0]          occupancy;
  logic [MISS_W-1:0]      miss_total;
  logic [ENTRIES-1:0]     entry_valid;
  logic [TAG_W-1:0]       key;
  logic [CW-1:0]          cnt;
  logic                   pipe_vld;
  logic [IW-1:0]          pipe_idx;

  logic [IW-1:0]          tgt;
  logic [OW-1:0]          thr;
  logic                   is_new;
  logic                   res_hit;
  logic                   res_evicted;
  logic [TAG_W-1:0]       res_evid;

  logic                   issue;
  logic                   pass_end;
  logic                   out_free;

  logic                   wr_en;
  logic [DW-1:0]          wr_data;
  logic [DW-1:0]          rd_data;
  logic [TAG_W-1:0]       rd_tag;
  logic [COUNT_BITS-1:0]  rd_count;
  logic [IW-1:0]          rd_rank;
  logic [COUNT_BITS-1:0]  count_inc;
  logic                   rd_valid;

  scan_ctl_t              scan_ctl;
  logic                   hit_found;
  logic [IW-1:0]          hit_idx;
  logic [IW-1:0]          hit_rank;
  logic                   vic_found;
  logic [IW-1:0]          vic_idx;
  logic [IW-1:0]          vic_rank;
  logic [TAG_W-1:0]       vic_tag;
  logic                   free_found;
  logic [IW-1:0]          free_idx;

  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;

  assign cfg_ready = !rst;
  assign in_ready  = (state == ST_IDLE) && !rst;
  assign out_free  = !out_valid || out_ready;

  assign issue    = ((state == ST_SCAN) || (state == ST_UPDATE)) && (cnt != CW'(ENTRIES));
  assign pass_end = (cnt == CW'(ENTRIES));

  assign rd_tag   = rd_data[DW-1 -: TAG_W];
  assign rd_count = rd_data[IW +: COUNT_BITS];
  assign rd_rank  = rd_data[IW-1:0];
  assign rd_valid = entry_valid[pipe_idx];
  assign count_inc = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count
                                                      : rd_count + COUNT_BITS'(1);

  // Capacity outside 1..ENTRIES clamps to the nearest end.
  assign cap_ext = CMP_W'(capacity);
  assign eff_cap = (capacity == '0) ? CMP_W'(1)
                 : ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
  assign full    = (CMP_W'(occupancy) >= eff_cap) && (occupancy != '0);

  assign scan_ctl.clear = in_valid && in_ready;
  assign scan_ctl.step  = (state == ST_SCAN) && pipe_vld;

  // Update pass: the target takes rank 0, valid entries below the threshold age.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data;
    if ((state == ST_UPDATE) && pipe_vld) begin
      if (pipe_idx == tgt) begin
        wr_en   = 1'b1;
        wr_data = is_new ? {key, COUNT_BITS'(1), IW'(0)} : {rd_tag, count_inc, IW'(0)};
      end else if (rd_valid && (OW'(rd_rank) < thr)) begin
        wr_en   = 1'b1;
        wr_data = {rd_tag, rd_count, rd_rank + IW'(1)};
      end
    end
  end

  lfu_entry_ram #(
    .DEPTH (ENTRIES),
    .AW    (IW),
    .DW    (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pipe_idx),
    .wr_data (wr_data),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  lfu_scan #(
    .IW         (IW),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .key        (key),
    .ent_valid  (rd_valid),
    .ent_idx    (pipe_idx),
    .ent_tag    (rd_tag),
    .ent_count  (rd_count),
    .ent_rank   (rd_rank),
    .hit_found  (hit_found),
    .hit_idx    (hit_idx),
    .hit_rank   (hit_rank),
    .vic_found  (vic_found),
    .vic_idx    (vic_idx),
    .vic_rank   (vic_rank),
    .vic_tag    (vic_tag),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  always_ff @(posedge clk) begin
    pipe_idx <= cnt[IW-1:0];
    if (in_valid && in_ready) begin
      key <= block_id;
    end
    if (state == ST_DECIDE) begin
      res_hit     <= hit_found;
      res_evicted <= 1'b0;
      res_evid    <= '0;
      is_new      <= !hit_found;
      if (hit_found) begin
        tgt <= hit_idx;
        thr <= OW'(hit_rank);
      end else if (full && vic_found) begin
        // Victim slot is reused in place; occupancy holds.
        tgt         <= vic_idx;
        thr         <= OW'(vic_rank);
        res_evicted <= 1'b1;
        res_evid    <= vic_tag;
      end else begin
        tgt <= free_idx;
        thr <= occupancy;
      end
    end
    if (state == ST_DONE && out_free) begin
      hit           <= res_hit;
      evicted       <= res_evicted;
      evicted_id    <= res_evid;
      misses_so_far <= miss_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      capacity    <= CAP_RESET;
      occupancy   <= '0;
      miss_total  <= '0;
      entry_valid <= '0;
      cnt         <= '0;
      pipe_vld    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      pipe_vld <= issue;
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pass_end) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!hit_found) begin
            if (miss_total != {MISS_W{1'b1}}) begin
              miss_total <= miss_total + MISS_W'(1);
            end
            if (!(full && vic_found)) begin
              occupancy <= occupancy + OW'(1);
            end
          end
          cnt   <= '0;
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (pipe_vld && (pipe_idx == tgt)) begin
            entry_valid[pipe_idx] <= 1'b1;
          end
          if (pass_end) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold the result until the output register drains.
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/lfu_cache_replacement_core_test.sv
`timescale 1ns / 100ps
// Testbench for lfu_cache_replacement_core. It sends block_id accesses and capacity
// writes with random idling, predicts each outcome and checks every result beat.
// Depends on lfu_pkg and the core RTL only.

localparam int LFU_ENTRIES    = 16;
localparam int LFU_COUNT_BITS = 16;

typedef struct packed {
  logic                       hit;
  logic                       evicted;
  logic [lfu_pkg::TAG_W-1:0]  evicted_id;
  logic [lfu_pkg::MISS_W-1:0] misses;
} access_outcome_t;

class lfu_scoreboard;
  logic [lfu_pkg::TAG_W-1:0]  tag_of [LFU_ENTRIES];
  bit                         in_use [LFU_ENTRIES];
  logic [LFU_COUNT_BITS-1:0]  uses   [LFU_ENTRIES];
  int unsigned                age    [LFU_ENTRIES];  // 0 is the most recent
  int unsigned                fill;
  logic [lfu_pkg::MISS_W-1:0] miss_count;
  logic [lfu_pkg::CAP_W-1:0]  capacity;
  access_outcome_t            outcome_q [$];
  int                         failures;

  function new();
    for (int i = 0; i < LFU_ENTRIES; i++) begin
      tag_of[i] = '0;
      in_use[i] = 1'b0;
      uses[i]   = '0;
      age[i]    = 0;
    end
    fill       = 0;
    miss_count = '0;
    capacity   = lfu_pkg::CAP_RESET;
    failures   = 0;
  endfunction

  function void set_capacity(input logic [lfu_pkg::CAP_W-1:0] value);
    capacity = value;
  endfunction

  function int pending();
    return outcome_q.size();
  endfunction

  function void note_access(input logic [lfu_pkg::TAG_W-1:0] id);
    access_outcome_t want;
    int found;
    int victim;
    int slot;
    int unsigned limit;
    int unsigned r;
    want   = '0;
    found  = -1;
    victim = -1;
    slot   = -1;
    for (int i = 0; i < LFU_ENTRIES; i++)
      if (found < 0 && in_use[i] && tag_of[i] == id) found = i;
    if (found >= 0) begin
      r = age[found];
      for (int i = 0; i < LFU_ENTRIES; i++)
        if (in_use[i] && age[i] < r) age[i]++;
      age[found] = 0;
      if (uses[found] != '1) uses[found]++;
      want.hit = 1'b1;
    end else begin
      if (miss_count != '1) miss_count++;
      limit = (capacity == 0) ? 1 : (capacity > LFU_ENTRIES) ? LFU_ENTRIES : capacity;
      if (fill >= limit && fill > 0) begin
        // lowest count goes; on a tie the most recent of them
        for (int i = 0; i < LFU_ENTRIES; i++)
          if (in_use[i] && (victim < 0 || uses[i] < uses[victim] ||
              (uses[i] == uses[victim] && age[i] < age[victim])))
            victim = i;
        if (victim >= 0) begin
          r = age[victim];
          want.evicted    = 1'b1;
          want.evicted_id = tag_of[victim];
          in_use[victim]  = 1'b0;
          fill--;
          for (int i = 0; i < LFU_ENTRIES; i++)
            if (in_use[i] && age[i] > r) age[i]--;
          slot = victim;
        end
      end
      if (slot < 0)
        for (int i = 0; i < LFU_ENTRIES; i++)
          if (slot < 0 && !in_use[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < LFU_ENTRIES; i++)
          if (in_use[i]) age[i]++;
        in_use[slot] = 1'b1;
        tag_of[slot] = id;
        uses[slot]   = LFU_COUNT_BITS'(1);
        age[slot]    = 0;
        fill++;
      end
    end
    want.misses = miss_count;
    outcome_q.insert(outcome_q.size(), want);
  endfunction

  function void flag(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    failures++;
  endfunction

  function void check_result(input logic h, input logic e,
                             input logic [lfu_pkg::TAG_W-1:0] eid,
                             input logic [lfu_pkg::MISS_W-1:0] m);
    access_outcome_t want;
    if (outcome_q.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual hit %b evicted %b id %h misses %h",
               $time, h, e, eid, m);
      failures++;
      return;
    end
    want = outcome_q.pop_front();
    if (h !== want.hit) flag("hit", want.hit, h);
    if (e !== want.evicted) flag("evicted", want.evicted, e);
    if (eid !== want.evicted_id) flag("evicted_id", want.evicted_id, eid);
    if (m !== want.misses) flag("misses_so_far", want.misses, m);
  endfunction
endclass

module lfu_cache_replacement_core_test;

  localparam int DRAIN_CYCLES = 2 * LFU_ENTRIES + 12;

  typedef enum int {HOT_SET, SWEEP, SPREAD} access_mix_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [lfu_pkg::CAP_W-1:0]  cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [lfu_pkg::TAG_W-1:0]  block_id;
  logic                       out_valid;
  logic                       out_ready;
  logic                       hit;
  logic                       evicted;
  logic [lfu_pkg::TAG_W-1:0]  evicted_id;
  logic [lfu_pkg::MISS_W-1:0] misses_so_far;

  lfu_scoreboard sb;
  bit            idle_on;
  bit            long_hold_req;

  lfu_cache_replacement_core #(
    .ENTRIES    (LFU_ENTRIES),
    .COUNT_BITS (LFU_COUNT_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .block_id      (block_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .evicted       (evicted),
    .evicted_id    (evicted_id),
    .misses_so_far (misses_so_far)
  );

  always #6 clk = ~clk;

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check each beat, stall in short bursts or one long hold-off.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(hit, evicted, evicted_id, misses_so_far);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 160;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hold valid until the beat is taken; keep it high if the next one follows at once.
  task automatic send_access(input logic [lfu_pkg::TAG_W-1:0] id);
    int gap;
    in_valid <= 1'b1;
    block_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(id);
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every outstanding access has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [lfu_pkg::CAP_W-1:0] cap, input int count,
                           input bit hold);
    logic [lfu_pkg::TAG_W-1:0] pool [$];
    logic [lfu_pkg::TAG_W-1:0] id;
    access_mix_t mix;
    int eff;
    int pool_size;
    int a;
    int b;
    int idx;
    settle();
    write_capacity(cap);
    if (hold) long_hold_req = 1'b1;
    eff       = (cap == 0) ? 1 : (cap > LFU_ENTRIES) ? LFU_ENTRIES : cap;
    pool_size = eff + $urandom_range(0, eff + 2);
    // near neighbors differ in one bit to stress the tag compare
    while (pool.size() < pool_size) begin
      if (pool.size() > 0 && $urandom_range(0, 2) == 0)
        pool.insert(pool.size(), pool[pool.size() - 1] ^ (32'd1 << $urandom_range(0, 31)));
      else
        pool.insert(pool.size(), $urandom());
    end
    mix = access_mix_t'($urandom_range(0, 2));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        id = $urandom();
      end else begin
        case (mix)
          HOT_SET: begin
            a   = $urandom_range(0, pool.size() - 1);
            b   = $urandom_range(0, pool.size() - 1);
            idx = (a < b) ? a : b;
          end
          SWEEP:   idx = n % pool.size();
          default: idx = $urandom_range(0, pool.size() - 1);
        endcase
        id = pool[idx];
      end
      send_access(id);
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    block_id      = '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity, extreme ids, repeated hits
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0000);
    send_access(32'h0000_0001);
    send_access(32'h8000_0000);
    // shrink below occupancy; ties on count evict the most recent
    settle();
    write_capacity(5'd3);
    send_access(32'hA5A5_A5A5);
    send_access(32'h5A5A_5A5A);
    send_access(32'h0000_0001);
    send_access(32'h7FFF_FFFF);
    // zero acts as one
    settle();
    write_capacity(5'd0);
    send_access(32'h1234_5678);
    send_access(32'h1234_5678);
    // above the entry count clamps to it
    settle();
    write_capacity(5'd31);
    send_access(32'hFEDC_BA98);
    send_access(32'h0000_0001);

    run_phase(5'd16, 110, 1'b0);
    run_phase(5'd1, 100, 1'b1);
    run_phase(5'd31, 110, 1'b0);
    run_phase(5'd0, 90, 1'b0);
    run_phase(5'd4, 110, 1'b0);
    run_phase(5'd17, 100, 1'b0);
    run_phase(5'd8, 110, 1'b0);
    run_phase(5'($urandom_range(2, 15)), 110, 1'b0);
    run_phase(5'($urandom_range(2, 15)), 110, 1'b0);
    idle_on = 1'b0;
    run_phase(5'd16, 120, 1'b0);
    settle();

    if (sb.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/lfu_pkg.sv
rtl/core/lfu_entry_ram.sv
rtl/core/lfu_scan.sv
rtl/core/lfu_cache_replacement_core.sv
sim/lfu_cache_replacement_core_test.sv
